// ===== hw/rtl/lfsq_pkg.sv =====
package lfsq_pkg;

  localparam int CFG_W       = 11;
  localparam int FIELD_W     = 11;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 11'd1024;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 11'd1024;

  typedef enum logic [0:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_ROW_COUNT  = 1'b1
  } reg_idx_t;

endpackage

// ===== hw/rtl/lfsq_ram.sv =====
module lfsq_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/largest_free_square_finder_core.sv =====
// Largest free square finder. Cells of a binary raster stream in row-major order, one per
// transaction (in_tdata[0] = 1 for a blocked cell), and after the last cell of each frame one
// result transaction reports the side of the largest all-free square and its 1-based top-left
// row and column; ties go to the later cell, and an all-blocked frame reports size 0 at
// row_count+1, row_length+1. Per-column state (upward free run and previous-row square size)
// sits in a single line-buffer RAM of MAX_COLS words with one read and one write per cycle; a
// back-to-back access to the same column is forwarded. The result is registered: the last cell
// passes stage 1 and then the result register. The block takes one cell per clock, but a last
// cell of a frame is held off while an earlier last cell is in stage 1 or an earlier result
// still waits in the output register, so one-cell frames cannot go back to back. No clearing
// pass is needed after reset: the first row ignores line-buffer data and writes each entry
// before a later row reads it. Write row_length and row_count only between frames.
module largest_free_square_finder_core
  import lfsq_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] blocked, [7:1] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [10:0] square_size, [21:11] top_row,
                                             // [32:22] left_col, [39:33] zero
);

  localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LW   = $clog2(MAX_COLS + 1);
  localparam int RLW  = $clog2(MAX_ROWS + 1);
  localparam int MAXD = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int VW   = $clog2(MAXD + 1);
  localparam int CWC  = (LW > CFG_W) ? LW : CFG_W;
  localparam int CWR  = (RLW > CFG_W) ? RLW : CFG_W;
  localparam int EX0  = (VW > FIELD_W) ? VW : FIELD_W;
  localparam int EX1  = (RAW > EX0) ? RAW : EX0;
  localparam int EXW  = ((AW > EX1) ? AW : EX1) + 1;

  // configuration
  logic [CFG_W-1:0] row_length_r, row_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      row_count_r  <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_ROW_LENGTH: row_length_r <= cfg_wdata;
        REG_ROW_COUNT:  row_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CWC-1:0] rl_ext, rl_clamp;
  logic [CWR-1:0] rc_ext, rc_clamp;
  logic [LW-1:0]  rl, rl_m1;
  logic [RLW-1:0] rc, rc_m1;

  always_comb begin
    rl_ext = CWC'(row_length_r);
    rc_ext = CWR'(row_count_r);
    if (rl_ext == '0) rl_clamp = CWC'(1);
    else if (rl_ext > CWC'(MAX_COLS)) rl_clamp = CWC'(MAX_COLS);
    else rl_clamp = rl_ext;
    if (rc_ext == '0) rc_clamp = CWR'(1);
    else if (rc_ext > CWR'(MAX_ROWS)) rc_clamp = CWR'(MAX_ROWS);
    else rc_clamp = rc_ext;
    rl    = rl_clamp[LW-1:0];
    rc    = rc_clamp[RLW-1:0];
    rl_m1 = rl - LW'(1);
    rc_m1 = rc - RLW'(1);
  end

  // position counters, advanced at accept
  logic [AW-1:0]  col_pos_r, col_pos_nxt, acc_c;
  logic [RAW-1:0] row_pos_r, row_pos_nxt, acc_r;
  logic           acc_eol, acc_eof, in_acc;

  logic s1_valid_r, s1_blk_r, s1_eof_r, s1_fwd_r;
  logic [AW-1:0]  s1_c_r;
  logic [RAW-1:0] s1_r_r;
  logic           s1_emit;
  logic           out_valid_r;

  always_comb begin
    acc_c   = (LW'(col_pos_r) < rl) ? col_pos_r : rl_m1[AW-1:0];
    acc_r   = (RLW'(row_pos_r) < rc) ? row_pos_r : rc_m1[RAW-1:0];
    acc_eol = (LW'(acc_c) == rl_m1);
    acc_eof = acc_eol && (RLW'(acc_r) == rc_m1);
    s1_emit = s1_valid_r && s1_eof_r;
    in_tready = !acc_eof || ((!out_valid_r || out_tready) && !s1_emit);
    in_acc  = in_tvalid && in_tready;
    if (acc_eol) begin
      col_pos_nxt = '0;
      row_pos_nxt = acc_eof ? '0 : acc_r + RAW'(1);
    end else begin
      col_pos_nxt = acc_c + AW'(1);
      row_pos_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_acc) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  // line buffer: {previous-row size, upward run}
  logic           ram_we;
  logic [2*VW-1:0] ram_wdata, ram_rdata, wr_hold_r, rd_word;

  lfsq_ram #(
    .WIDTH (2 * VW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_c_r),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (acc_c),
    .rdata (ram_rdata)
  );

  // stage 1: read data arrives, cell is evaluated and written back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s1_fwd_r   <= in_acc && s1_valid_r && (s1_c_r == acc_c);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_blk_r <= in_tdata[0];
      s1_c_r   <= acc_c;
      s1_r_r   <= acc_r;
      s1_eof_r <= acc_eof;
    end
    if (ram_we) begin
      wr_hold_r <= ram_wdata;
    end
  end

  logic [VW-1:0]  h_r, h_nxt, diag_r, diag_nxt;
  logic [VW-1:0]  up, above, h_prev, diag_prev, u_new, s_new, m_hu, d_p1;
  logic [VW-1:0]  best_size_r, best_size_nxt;
  logic [RAW-1:0] best_row_r, best_row_nxt;
  logic [AW-1:0]  best_col_r, best_col_nxt;
  logic [EXW-1:0] top_ex, left_ex;

  always_comb begin
    rd_word   = s1_fwd_r ? wr_hold_r : ram_rdata;
    up        = (s1_r_r == '0) ? '0 : rd_word[VW-1:0];
    above     = (s1_r_r == '0) ? '0 : rd_word[2*VW-1:VW];
    h_prev    = (s1_c_r == '0) ? '0 : h_r;
    diag_prev = (s1_c_r == '0) ? '0 : diag_r;
    if (s1_blk_r) begin
      h_nxt = '0;
      u_new = '0;
      s_new = '0;
      m_hu  = '0;
      d_p1  = '0;
    end else begin
      h_nxt = h_prev + VW'(1);
      u_new = up + VW'(1);
      d_p1  = diag_prev + VW'(1);
      m_hu  = (h_nxt < u_new) ? h_nxt : u_new;
      s_new = (m_hu < d_p1) ? m_hu : d_p1;
    end
    diag_nxt  = above;
    ram_we    = s1_valid_r;
    ram_wdata = {s_new, u_new};
    if (s_new >= best_size_r) begin
      best_size_nxt = s_new;
      best_row_nxt  = s1_r_r;
      best_col_nxt  = s1_c_r;
    end else begin
      best_size_nxt = best_size_r;
      best_row_nxt  = best_row_r;
      best_col_nxt  = best_col_r;
    end
    top_ex  = EXW'(best_row_nxt) + EXW'(2) - EXW'(best_size_nxt);
    left_ex = EXW'(best_col_nxt) + EXW'(2) - EXW'(best_size_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_valid_r) begin
      if (s1_eof_r) begin
        h_r         <= '0;
        diag_r      <= '0;
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        h_r         <= h_nxt;
        diag_r      <= diag_nxt;
        best_size_r <= best_size_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end
    end
  end

  // result register
  logic [FIELD_W-1:0] out_size_r, out_top_r, out_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_size_r <= FIELD_W'(best_size_nxt);
      out_top_r  <= top_ex[FIELD_W-1:0];
      out_left_r <= left_ex[FIELD_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 3 * FIELD_W){1'b0}}, out_left_r, out_top_r, out_size_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  a_fwd_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> (s1_valid_r && $past(s1_valid_r)))
    else $error("forward without back-to-back cells");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_eof_r))
    else $error("result without frame end");

endmodule
